// ===== rtl/ar_pkg.sv =====
`default_nettype none
package ar_pkg;

  // Table geometry and field widths.
  localparam int FRAMES    = 64;
  localparam int AGE_BITS  = 16;
  localparam int PAGE_BITS = 20;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);

  // Fixed widths of the configuration and result words.
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FIU_W       = 7;
  localparam int PERIOD_W    = 16;
  localparam int MARK_W      = 16;
  localparam int OUT_IDX_W   = 6;
  localparam int FAULT_W     = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_MARK = 2'd2;

  // Outcome codes.
  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_LOAD    = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // Search word that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [AGE_BITS-1:0]  min_age;
    logic [IDX_W-1:0]     min_idx;
    logic [PAGE_BITS-1:0] min_page;
  } carrier_t;

  // Update broadcast to all cells at the end of a sweep.
  typedef struct packed {
    logic                 wr;
    logic                 orr;
    logic                 shift;
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] page;
    logic [AGE_BITS-1:0]  mark;
  } update_t;

endpackage
`default_nettype wire

// ===== rtl/ar_cell.sv =====
`default_nettype none
module ar_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [ar_pkg::IDX_W-1:0] cell_idx,
  input  wire logic [ar_pkg::CNT_W-1:0] frames_loaded,
  input  wire ar_pkg::carrier_t         carry_in,
  input  wire ar_pkg::update_t          upd,
  output ar_pkg::carrier_t              carry_out
);

  logic [ar_pkg::PAGE_BITS-1:0] page_r, page_nxt;
  logic [ar_pkg::AGE_BITS-1:0]  age_r, age_nxt, age_mid;
  ar_pkg::carrier_t             carry_r, carry_nxt;
  logic                         loaded, match, take, sel;

  // A frame is resident when its index lies below the fill count.
  assign loaded = (ar_pkg::CNT_W'(cell_idx) < frames_loaded);
  assign match  = loaded && (page_r == carry_in.page);
  assign take   = loaded && ((age_r < carry_in.min_age) || (cell_idx == '0));

  // Fold this frame into the passing search word.
  always_comb begin
    carry_nxt = carry_in;
    if (match && !carry_in.hit) begin
      carry_nxt.hit     = 1'b1;
      carry_nxt.hit_idx = cell_idx;
    end
    if (take) begin
      carry_nxt.min_age  = age_r;
      carry_nxt.min_idx  = cell_idx;
      carry_nxt.min_page = page_r;
    end
  end

  // Apply the broadcast update, then the aging shift.
  assign sel = (upd.idx == cell_idx);
  always_comb begin
    page_nxt = page_r;
    age_mid  = age_r;
    if (upd.wr && sel) begin
      page_nxt = upd.page;
      age_mid  = upd.mark;
    end else if (upd.orr && sel) begin
      age_mid = age_r | upd.mark;
    end
    age_nxt = upd.shift ? (age_mid >> 1) : age_mid;
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    age_r  <= age_nxt;
  end

  // Only the valid flag of the search word is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.valid <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;

endmodule
`default_nettype wire

// ===== rtl/aging_page_replacement.sv =====
// Aging page replacement over a chain of frame cells.
// The search word passes through the register of every frame cell in turn, and then the
// result word and strobe are registered; the strobe lasts one cycle and cannot be stalled.
// A new page is accepted only when idle: busy holds off start while the search word walks
// the cell chain, one frame per cycle, before the table update.
// Reset (rst_n low, synchronous): counters and control clear; the frame table is not cleared.
`default_nettype none
module aging_page_replacement (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ar_pkg::PAGE_BITS-1:0] in_page_number,
  output logic                              out_valid,
  output logic [1:0]                        out_outcome,
  output logic [ar_pkg::OUT_IDX_W-1:0]      out_frame_index,
  output logic [ar_pkg::PAGE_BITS-1:0]      out_evicted_page,
  output logic [ar_pkg::FAULT_W-1:0]        out_fault_count,
  input  wire logic                         cfg_we,
  input  wire logic [ar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ar_pkg::CFG_W-1:0]     cfg_wdata
);

  ar_pkg::state_t                 state_r, state_nxt;
  logic [ar_pkg::FIU_W-1:0]       fiu_r;
  logic [ar_pkg::PERIOD_W-1:0]    period_r;
  logic [ar_pkg::MARK_W-1:0]      mark_r;
  logic [ar_pkg::CNT_W-1:0]       loaded_r, loaded_nxt;
  logic [ar_pkg::PERIOD_W-1:0]    pcnt_r, pcnt_nxt;
  logic [ar_pkg::FAULT_W-1:0]     fault_r, fault_nxt;
  logic                           out_valid_r;
  logic [1:0]                     outcome_r, outcome_nxt;
  logic [ar_pkg::OUT_IDX_W-1:0]   frame_idx_r;
  logic [ar_pkg::PAGE_BITS-1:0]   evicted_r, evicted_nxt;
  logic [ar_pkg::IDX_W-1:0]       frame_nxt;
  logic [ar_pkg::CNT_W-1:0]       limit;
  logic [ar_pkg::AGE_BITS-1:0]    mark_age;
  logic                           accept, done, age_tick;
  ar_pkg::carrier_t               chain [ar_pkg::FRAMES+1];
  ar_pkg::carrier_t               tail;
  ar_pkg::update_t                upd;

  assign accept = start && !busy;
  assign tail   = chain[ar_pkg::FRAMES];
  assign done   = (state_r == ar_pkg::ST_SWEEP) && tail.valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r    <= ar_pkg::FIU_W'(64);
      period_r <= ar_pkg::PERIOD_W'(1);
      mark_r   <= ar_pkg::MARK_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        ar_pkg::CFG_FRAMES_IN_USE:  fiu_r    <= cfg_wdata[ar_pkg::FIU_W-1:0];
        ar_pkg::CFG_AGING_PERIOD:   period_r <= cfg_wdata[ar_pkg::PERIOD_W-1:0];
        ar_pkg::CFG_REFERENCE_MARK: mark_r   <= cfg_wdata[ar_pkg::MARK_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame limit clamped to one through the table size.
  always_comb begin
    if (fiu_r == '0) begin
      limit = ar_pkg::CNT_W'(1);
    end else if (32'(fiu_r) > 32'(ar_pkg::FRAMES)) begin
      limit = ar_pkg::CNT_W'(ar_pkg::FRAMES);
    end else begin
      limit = ar_pkg::CNT_W'(fiu_r);
    end
  end

  assign mark_age = ar_pkg::AGE_BITS'(32'(mark_r));

  // Search word launched into the first cell on acceptance.
  assign chain[0] = '{valid:    accept,
                      page:     in_page_number,
                      hit:      1'b0,
                      hit_idx:  '0,
                      min_age:  '1,
                      min_idx:  '0,
                      min_page: '0};

  for (genvar g = 0; g < ar_pkg::FRAMES; g++) begin : g_cell
    ar_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (ar_pkg::IDX_W'(g)),
      .frames_loaded(loaded_r),
      .carry_in     (chain[g]),
      .upd          (upd),
      .carry_out    (chain[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ar_pkg::ST_IDLE:  if (accept) state_nxt = ar_pkg::ST_SWEEP;
      ar_pkg::ST_SWEEP: if (done) state_nxt = ar_pkg::ST_IDLE;
      default:          state_nxt = ar_pkg::ST_IDLE;
    endcase
  end

  // Decision at the end of the sweep and the update sent to the cells.
  always_comb begin
    busy        = (state_r == ar_pkg::ST_SWEEP);
    age_tick    = (pcnt_r == period_r) || (period_r == ar_pkg::PERIOD_W'(1));
    loaded_nxt  = loaded_r;
    fault_nxt   = fault_r;
    pcnt_nxt    = pcnt_r;
    outcome_nxt = ar_pkg::OUT_HIT;
    frame_nxt   = tail.hit_idx;
    evicted_nxt = '0;
    upd.wr      = 1'b0;
    upd.orr     = 1'b0;
    upd.shift   = 1'b0;
    upd.idx     = tail.hit_idx;
    upd.page    = tail.page;
    upd.mark    = mark_age;
    if (done) begin
      upd.shift = age_tick;
      pcnt_nxt  = age_tick ? ar_pkg::PERIOD_W'(1) : pcnt_r + 1'b1;
      if (tail.hit) begin
        upd.orr = 1'b1;
      end else if (loaded_r >= limit) begin
        outcome_nxt = ar_pkg::OUT_REPLACE;
        frame_nxt   = tail.min_idx;
        evicted_nxt = tail.min_page;
        upd.wr      = 1'b1;
        upd.idx     = tail.min_idx;
        if (fault_r != '1) fault_nxt = fault_r + 1'b1;
      end else begin
        outcome_nxt = ar_pkg::OUT_LOAD;
        frame_nxt   = loaded_r[ar_pkg::IDX_W-1:0];
        upd.wr      = 1'b1;
        upd.idx     = loaded_r[ar_pkg::IDX_W-1:0];
        loaded_nxt  = loaded_r + 1'b1;
      end
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ar_pkg::ST_IDLE;
      loaded_r    <= '0;
      pcnt_r      <= ar_pkg::PERIOD_W'(1);
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      pcnt_r      <= pcnt_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= done;
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (done) begin
      outcome_r   <= outcome_nxt;
      frame_idx_r <= ar_pkg::OUT_IDX_W'(32'(frame_nxt));
      evicted_r   <= evicted_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_frame_index  = frame_idx_r;
  assign out_evicted_page = evicted_r;
  assign out_fault_count  = fault_r;

endmodule
`default_nettype wire
